// ===== rtl/stereo_ping_pong_delay_macros.svh =====
// Assertion macros for the stereo ping-pong delay checker.
// Uses the names clk and arst_n of the module that expands them.
`ifndef STEREO_PING_PONG_DELAY_MACROS_SVH
`define STEREO_PING_PONG_DELAY_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spd check failed: next-cycle rule");

// consequent checked in the same cycle as the antecedent
`define SPD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spd check failed: same-cycle rule");

`endif

// ===== rtl/spd_pkg.sv =====
// Shared types, constants and helper functions of the stereo ping-pong delay.
// No dependencies; used by the interfaces, sequencer, datapath, top level and checker.
package spd_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int DLY_W     = 26;
	localparam int CFG_W     = 26;
	localparam int CFG_IDX_W = 2;

	localparam logic [16:0] UNITY  = 17'd65536;
	localparam logic [15:0] FB_MAX = 16'd58982;

	localparam logic [16:0]      BALANCE_RST  = 17'd16384;
	localparam logic [DLY_W-1:0] DELAY_RST    = 26'd1228800;
	localparam logic [15:0]      FEEDBACK_RST = 16'd45875;
	localparam logic [16:0]      MIX_RST      = 17'd6554;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BALANCE  = 2'd0,
		REG_DELAY    = 2'd1,
		REG_FEEDBACK = 2'd2,
		REG_MIX      = 2'd3
	} cfg_reg_t;

	// settings as seen by the datapath; balance, feedback and mix are clamped
	typedef struct packed {
		logic [16:0]      bal;
		logic [DLY_W-1:0] delay;
		logic [15:0]      fb;
		logic [16:0]      mix;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic red;
		logic pos;
		logic idx;
		logic nxt;
		logic rd_nxt;
		logic cap_a;
		logic cap_b;
		logic ip1;
		logic ip2;
		logic mul;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic red_last;
	} stat_t;

	function automatic sample_t sat24(input logic signed [31:0] x);
		if (x > 32'sd8388607)
			return 24'sh7FFFFF;
		else if (x < -32'sd8388608)
			return 24'sh800000;
		else
			return x[SAMPLE_W-1:0];
	endfunction

	// compare-subtract steps needed to fold a delay word below span
	function automatic int red_steps(input longint span);
		int n;
		n = 0;
		for (int k = 0; k < DLY_W; k++) begin
			if ((span << k) < (longint'(1) << DLY_W))
				n++;
		end
		return n;
	endfunction

endpackage

// ===== rtl/spd_if.sv =====
// Stream interfaces for frames into and out of the stereo ping-pong delay.
// Depends on spd_pkg.
interface spd_in_if;
	import spd_pkg::*;
	logic    valid;
	logic    ready;
	sample_t left_in;
	sample_t right_in;
	modport source (output valid, output left_in, output right_in, input ready);
	modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface spd_out_if;
	import spd_pkg::*;
	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;
	modport source (output valid, output left_out, output right_out, input ready);
	modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/spd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/spd_ctrl.sv =====
// Sequencer of the stereo ping-pong delay: steps one frame through the datapath.
// Depends on spd_pkg.
module spd_ctrl #(
	parameter int RED_STEPS = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output spd_pkg::cmd_t  cmd,
	input  spd_pkg::stat_t stat
);
	import spd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED,
		ST_POS,
		ST_IDX,
		ST_RD0,
		ST_RD1,
		ST_CAP,
		ST_IP1,
		ST_IP2,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_vld_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load   = in_valid;
			ST_RED:  cmd.red    = 1'b1;
			ST_POS:  cmd.pos    = 1'b1;
			ST_IDX:  cmd.idx    = 1'b1;
			ST_RD0:  cmd.nxt    = 1'b1;
			ST_RD1: begin
				cmd.rd_nxt = 1'b1;
				cmd.cap_a  = 1'b1;
			end
			ST_CAP:  cmd.cap_b  = 1'b1;
			ST_IP1:  cmd.ip1    = 1'b1;
			ST_IP2:  cmd.ip2    = 1'b1;
			ST_MUL:  cmd.mul    = 1'b1;
			// result slot must be empty or emptying this cycle
			ST_FIN:  cmd.commit = !out_vld_q || out_ready;
			default: cmd = '0;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= (RED_STEPS > 0) ? ST_RED : ST_POS;
				end
				ST_RED: begin
					if (stat.red_last)
						state_q <= ST_POS;
				end
				ST_POS:  state_q <= ST_IDX;
				ST_IDX:  state_q <= ST_RD0;
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_CAP;
				ST_CAP:  state_q <= ST_IP1;
				ST_IP1:  state_q <= ST_IP2;
				ST_IP2:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_FIN;
				ST_FIN: begin
					if (cmd.commit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/spd_dp.sv =====
// Datapath of the stereo ping-pong delay: delay lines, read position,
// interpolation, mixing and cross feedback. Depends on spd_pkg and spd_ram.
module spd_dp #(
	parameter int LINE_DEPTH = 262144
) (
	input  logic             clk,
	input  logic             arst_n,
	input  spd_pkg::cmd_t    cmd,
	output spd_pkg::stat_t   stat,
	input  spd_pkg::cfg_t    cfg,
	input  spd_pkg::sample_t left_in,
	input  spd_pkg::sample_t right_in,
	output spd_pkg::sample_t left_out,
	output spd_pkg::sample_t right_out
);
	import spd_pkg::*;

	localparam int          AW        = $clog2(LINE_DEPTH);
	localparam int          PW        = AW + 9;
	localparam longint      SPAN      = longint'(LINE_DEPTH) * 256;
	localparam logic [63:0] SPAN_V    = 64'(SPAN);
	localparam int          RED_STEPS = red_steps(SPAN);
	localparam int          RCW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

	// control state
	logic [AW-1:0]  wp_q;
	logic           filled_q;
	logic [RCW-1:0] rcnt_q;

	// frame payload
	sample_t                  xl_q, xr_q;
	logic [DLY_W-1:0]         dmod_q;
	logic [PW-1:0]            pos_raw_q;
	sample_t                  inl_q, inr_q;
	logic [AW-1:0]            idx_q, nxt_q;
	logic [7:0]               frac_q;
	logic                     skip_q;
	logic                     rdv_q;
	sample_t                  al_q, ar_q, bl_q, br_q;
	logic signed [33:0]       pl_q, pr_q;
	sample_t                  wl_q, wr_q;
	logic signed [42:0]       ml_q, mr_q;
	logic signed [40:0]       fl_q, fr_q;
	sample_t                  out_l_q, out_r_q;

	logic [DLY_W-1:0]   sub_val;
	logic [16:0]        ibal;
	logic signed [41:0] wgt_l, wgt_r;
	logic [PW-1:0]      pos;
	logic [AW-1:0]      raddr;
	logic [SAMPLE_W-1:0] ram_l, ram_r;
	sample_t            rd_l, rd_r;
	logic signed [34:0] itp_l, itp_r;
	logic signed [42:0] ml_rs, mr_rs;
	logic signed [40:0] fl_rs, fr_rs;
	sample_t            yl, yr, line_l, line_r;
	logic               we;

	assign stat.red_last = (rcnt_q == '0);

	always_comb begin
		sub_val = DLY_W'(SPAN_V << rcnt_q);
		ibal    = UNITY - cfg.bal;
		wgt_l   = (42'(xl_q) * 42'($signed({1'b0, ibal})) + 42'sd32768) >>> 16;
		wgt_r   = (42'(xr_q) * 42'($signed({1'b0, cfg.bal})) + 42'sd32768) >>> 16;
		pos     = (pos_raw_q >= PW'(SPAN)) ? pos_raw_q - PW'(SPAN) : pos_raw_q;
		raddr   = cmd.rd_nxt ? nxt_q : idx_q;
		// entries not yet written since reset read as zero
		rd_l    = rdv_q ? sample_t'(ram_l) : '0;
		rd_r    = rdv_q ? sample_t'(ram_r) : '0;
		itp_l   = ((35'(al_q) <<< 8) + 35'(pl_q) + 35'sd128) >>> 8;
		itp_r   = ((35'(ar_q) <<< 8) + 35'(pr_q) + 35'sd128) >>> 8;
		ml_rs   = (ml_q + 43'sd32768) >>> 16;
		mr_rs   = (mr_q + 43'sd32768) >>> 16;
		fl_rs   = (fl_q + 41'sd32768) >>> 16;
		fr_rs   = (fr_q + 41'sd32768) >>> 16;
		yl      = skip_q ? xl_q : sat24(32'(inl_q) + 32'($signed(ml_rs[26:0])));
		yr      = skip_q ? xr_q : sat24(32'(inr_q) + 32'($signed(mr_rs[26:0])));
		line_l  = skip_q ? '0 : sat24(32'(inl_q) + 32'($signed(fl_rs[24:0])));
		line_r  = skip_q ? '0 : sat24(32'(inr_q) + 32'($signed(fr_rs[24:0])));
		// a skipped write still clears the entry during the first pass
		we      = cmd.commit && (!skip_q || !filled_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			filled_q <= 1'b0;
			rcnt_q   <= '0;
		end else begin
			if (cmd.load)
				rcnt_q <= RCW'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);
			else if (cmd.red)
				rcnt_q <= rcnt_q - 1'b1;
			if (cmd.commit) begin
				if (wp_q == AW'(LINE_DEPTH - 1)) begin
					wp_q     <= '0;
					filled_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rdv_q <= filled_q || (raddr < wp_q);
		if (cmd.load) begin
			xl_q   <= left_in;
			xr_q   <= right_in;
			dmod_q <= cfg.delay;
		end
		// fold the delay below the line span, largest multiple first
		if (cmd.red && dmod_q >= sub_val)
			dmod_q <= dmod_q - sub_val;
		if (cmd.pos) begin
			pos_raw_q <= PW'({wp_q, 8'h00}) + PW'(SPAN) - PW'(dmod_q);
			inl_q     <= wgt_l[SAMPLE_W-1:0];
			inr_q     <= wgt_r[SAMPLE_W-1:0];
		end
		if (cmd.idx) begin
			idx_q  <= pos[AW+7:8];
			frac_q <= pos[7:0];
			skip_q <= (pos[AW+7:8] == wp_q);
		end
		if (cmd.nxt)
			nxt_q <= (idx_q == AW'(LINE_DEPTH - 1)) ? '0 : idx_q + 1'b1;
		if (cmd.cap_a) begin
			al_q <= rd_l;
			ar_q <= rd_r;
		end
		if (cmd.cap_b) begin
			bl_q <= rd_l;
			br_q <= rd_r;
		end
		if (cmd.ip1) begin
			pl_q <= 34'(25'(bl_q) - 25'(al_q)) * 34'($signed({1'b0, frac_q}));
			pr_q <= 34'(25'(br_q) - 25'(ar_q)) * 34'($signed({1'b0, frac_q}));
		end
		if (cmd.ip2) begin
			wl_q <= itp_l[SAMPLE_W-1:0];
			wr_q <= itp_r[SAMPLE_W-1:0];
		end
		if (cmd.mul) begin
			ml_q <= 43'(25'(wl_q) - 25'(inl_q)) * 43'($signed({1'b0, cfg.mix}));
			mr_q <= 43'(25'(wr_q) - 25'(inr_q)) * 43'($signed({1'b0, cfg.mix}));
			// cross feedback: right wet into the left line and vice versa
			fl_q <= 41'(wr_q) * 41'($signed({1'b0, cfg.fb}));
			fr_q <= 41'(wl_q) * 41'($signed({1'b0, cfg.fb}));
		end
		if (cmd.commit) begin
			out_l_q <= yl;
			out_r_q <= yr;
		end
	end

	assign left_out  = out_l_q;
	assign right_out = out_r_q;

	spd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(LINE_DEPTH)
	) u_left_line (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (line_l),
		.raddr (raddr),
		.rdata (ram_l)
	);

	spd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(LINE_DEPTH)
	) u_right_line (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (line_r),
		.raddr (raddr),
		.rdata (ram_r)
	);
endmodule

// ===== rtl/stereo_ping_pong_delay.sv =====
// Top level of the stereo ping-pong delay: settings registers, sequencer and datapath.
// Depends on spd_pkg, spd_if, spd_ctrl and spd_dp.
//
//   port        dir  handshake      payload
//   in_frame    in   valid/ready    left_in, right_in (s24)
//   out_frame   out  valid/ready    left_out, right_out (s24)
//   cfg_*       in   cfg_we only    cfg_idx, cfg_wdata (26 b)
//
// A new frame is taken only in idle, once the last one is committed. Each frame
// runs the delay fold steps (0 at the default depth, up to 17 for the shortest
// lines), then the two reads per frame on the single read port of each
// line RAM and the registered multiply stages. A finished result sits in the
// output register while the next frame is taken; a stalled output holds the
// next result in its last step. The lines are not cleared after reset: a fill
// flag makes unwritten entries read as zero until the write pointer first wraps.
module stereo_ping_pong_delay #(
	parameter int LINE_DEPTH = 262144
) (
	input  logic                           clk,
	input  logic                           arst_n,
	spd_in_if.sink                         in_frame,
	spd_out_if.source                      out_frame,
	input  logic                           cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spd_pkg::CFG_W-1:0]      cfg_wdata
);
	import spd_pkg::*;

	localparam int RED_STEPS = red_steps(longint'(LINE_DEPTH) * 256);

	logic [16:0]      balance_q;
	logic [DLY_W-1:0] delay_q;
	logic [15:0]      feedback_q;
	logic [16:0]      mix_q;
	cfg_t             cfg;
	cmd_t             cmd;
	stat_t            stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			balance_q  <= BALANCE_RST;
			delay_q    <= DELAY_RST;
			feedback_q <= FEEDBACK_RST;
			mix_q      <= MIX_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_BALANCE:  balance_q  <= cfg_wdata[16:0];
				REG_DELAY:    delay_q    <= cfg_wdata[DLY_W-1:0];
				REG_FEEDBACK: feedback_q <= cfg_wdata[15:0];
				REG_MIX:      mix_q      <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.bal   = (balance_q > UNITY) ? UNITY : balance_q;
		cfg.delay = delay_q;
		cfg.fb    = (feedback_q > FB_MAX) ? FB_MAX : feedback_q;
		cfg.mix   = (mix_q > UNITY) ? UNITY : mix_q;
	end

	spd_ctrl #(
		.RED_STEPS(RED_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_frame.valid),
		.in_ready  (in_frame.ready),
		.out_valid (out_frame.valid),
		.out_ready (out_frame.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	spd_dp #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg),
		.left_in   (in_frame.left_in),
		.right_in  (in_frame.right_in),
		.left_out  (out_frame.left_out),
		.right_out (out_frame.right_out)
	);
endmodule

// ===== rtl/spd_chk.sv =====
// Port-level checker for the stereo ping-pong delay, bound to the top level.
// Depends on spd_pkg and the macros header.
`include "stereo_ping_pong_delay_macros.svh"

module spd_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input spd_pkg::sample_t left_out,
	input spd_pkg::sample_t right_out
);
	// a frame keeps the block busy right after its transfer
	`SPD_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready ##1 !in_ready)
	// a new result shows up only as the block returns to idle
	`SPD_ASSERT_SAME(a_result_at_idle, $rose(out_valid), in_ready && !$past(in_ready))
	`SPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`SPD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
		$stable(left_out) && $stable(right_out))
endmodule

bind stereo_ping_pong_delay spd_chk u_spd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_frame.valid),
	.in_ready  (in_frame.ready),
	.out_valid (out_frame.valid),
	.out_ready (out_frame.ready),
	.left_out  (out_frame.left_out),
	.right_out (out_frame.right_out)
);
